>>> design/jaip_pkg.sv
`timescale 1ns / 1ps

package jaip_pkg;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 32;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [BYTE_W-1:0] MARK_FF   = 8'hFF;
    localparam logic [BYTE_W-1:0] MARK_SOI  = 8'hD8;
    localparam logic [BYTE_W-1:0] MARK_APP0 = 8'hE0;
    localparam logic [BYTE_W-1:0] MARK_APP2 = 8'hE2;

    localparam logic [LEN_W-1:0] MAX_BLOB     = 16'd65533;
    localparam logic [LEN_W-1:0] LEN_FIELD_OH = 16'd2;
    localparam logic [POS_W-1:0] CAND_RESET   = 32'd2;

    localparam logic REG_BLOB_LENGTH = 1'b0;

    typedef enum logic [7:0] {
        PH_SOI0   = 8'b0000_0001,
        PH_SOI1   = 8'b0000_0010,
        PH_APP0FF = 8'b0000_0100,
        PH_APP0ID = 8'b0000_1000,
        PH_LENHI  = 8'b0001_0000,
        PH_LENLO  = 8'b0010_0000,
        PH_SEEK   = 8'b0100_0000,
        PH_APP2ID = 8'b1000_0000
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERT  = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_SOI = 2'd2,
        ST_BEYOND  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FLT_NONE = 2'd0,
        FLT_SOI  = 2'd2,
        FLT_OVF  = 2'd3
    } t_fault;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   insert_offset;
        logic [LEN_W-1:0]   segment_length;
    } t_result;

endpackage

>>> design/jaip_if.sv
`timescale 1ns / 1ps

interface jaip_in_if;
    logic                          valid;
    logic                          ready;
    logic [jaip_pkg::BYTE_W-1:0]   image_byte;
    logic                          last_byte;

    modport source (output valid, output image_byte, output last_byte, input ready);
    modport sink (input valid, input image_byte, input last_byte, output ready);
endinterface

interface jaip_out_if;
    logic                           valid;
    logic                           ready;
    logic [jaip_pkg::STATUS_W-1:0]  status;
    logic [jaip_pkg::POS_W-1:0]     insert_offset;
    logic [jaip_pkg::LEN_W-1:0]     segment_length;

    modport source (output valid, output status, output insert_offset,
                    output segment_length, input ready);
    modport sink (input valid, input status, input insert_offset,
                  input segment_length, output ready);
endinterface

>>> design/jpeg_app1_insert_point_finder_core.sv
// A result is registered when the byte marked last is taken, into the output or skid entry.
// Throughput: one byte per cycle unless the result buffer is full; one compare, one add.
// A two-entry result buffer keeps input flowing while a result waits at the output.
// Reset (synchronous, active low) returns the parser to the SOI check, empties the
// result buffer and clears blob_length to zero.
`timescale 1ns / 1ps

module jpeg_app1_insert_point_finder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    jaip_in_if.sink                           i_in,
    jaip_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jaip_pkg::ADDR_W-1:0]       paddr,
    input  logic [jaip_pkg::DATA_W-1:0]       pwdata,
    output logic [jaip_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import jaip_pkg::*;

    logic [LEN_W-1:0]   r_blob_length;
    logic [POS_W-1:0]   r_byte_position, n_byte_position;
    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_length_high, n_length_high;
    logic [POS_W-1:0]   r_cand, n_cand;
    logic               r_settled, n_settled;
    t_fault             r_fault, n_fault;

    t_result            r_out, r_skid, n_result;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    logic               r_ready;

    logic               in_xfer;
    logic               push;
    logic               pop;
    logic [POS_W:0]     seg_sum;
    logic [POS_W:0]     size;
    logic               blob_bad;
    t_status            status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLOB_LENGTH) ?
                    {{(DATA_W-LEN_W){1'b0}}, r_blob_length} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blob_length <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLOB_LENGTH) begin
            r_blob_length <= pwdata[LEN_W-1:0];
        end
    end

    assign in_xfer    = i_in.valid && r_ready;
    assign i_in.ready = r_ready;

    always_comb begin
        n_phase       = r_phase;
        n_length_high = r_length_high;
        n_cand        = r_cand;
        n_settled     = r_settled;
        n_fault       = r_fault;
        seg_sum       = {1'b0, r_cand} + {{(POS_W-1){1'b0}}, 2'd2}
                        + {{(POS_W+1-LEN_W){1'b0}}, r_length_high, i_in.image_byte};
        unique case (r_phase)
            PH_SOI0: begin
                if (i_in.image_byte == MARK_FF) begin
                    n_phase = PH_SOI1;
                end else begin
                    n_fault   = FLT_SOI;
                    n_settled = 1'b1;
                    n_phase   = PH_SEEK;
                end
            end
            PH_SOI1: begin
                if (i_in.image_byte == MARK_SOI) begin
                    n_phase = PH_APP0FF;
                end else begin
                    n_fault   = FLT_SOI;
                    n_settled = 1'b1;
                    n_phase   = PH_SEEK;
                end
            end
            PH_APP0FF: begin
                if (i_in.image_byte == MARK_FF) begin
                    n_phase = PH_APP0ID;
                end else begin
                    n_settled = 1'b1;
                    n_phase   = PH_SEEK;
                end
            end
            PH_APP0ID: begin
                if (i_in.image_byte == MARK_APP0) begin
                    n_phase = PH_LENHI;
                end else begin
                    n_settled = 1'b1;
                    n_phase   = PH_SEEK;
                end
            end
            PH_LENHI: begin
                n_length_high = i_in.image_byte;
                n_phase       = PH_LENLO;
            end
            PH_LENLO: begin
                n_phase = PH_SEEK;
                if (seg_sum[POS_W]) begin
                    n_cand    = '1;
                    n_fault   = FLT_OVF;
                    n_settled = 1'b1;
                end else begin
                    n_cand = seg_sum[POS_W-1:0];
                    if (seg_sum <= {1'b0, r_byte_position}) begin
                        n_settled = 1'b1;
                    end
                end
            end
            PH_SEEK: begin
                if (!r_settled && r_byte_position == r_cand) begin
                    if (i_in.image_byte == MARK_FF) begin
                        n_phase = PH_APP2ID;
                    end else begin
                        n_settled = 1'b1;
                    end
                end
            end
            PH_APP2ID: begin
                if (i_in.image_byte == MARK_APP2) begin
                    n_phase = PH_LENHI;
                end else begin
                    n_settled = 1'b1;
                    n_phase   = PH_SEEK;
                end
            end
            default: begin
                n_phase = PH_SOI0;
            end
        endcase
    end

    assign n_byte_position = (r_byte_position == '1) ? r_byte_position
                                                     : r_byte_position + 1'b1;

    assign size     = {1'b0, r_byte_position} + 1'b1;
    assign blob_bad = (r_blob_length == '0) || (r_blob_length > MAX_BLOB);

    always_comb begin
        priority if (r_byte_position < 32'd3 || blob_bad) begin
            status = ST_SHORT;
        end else if (n_fault == FLT_SOI) begin
            status = ST_BAD_SOI;
        end else if (n_fault == FLT_OVF || {1'b0, n_cand} > size) begin
            status = ST_BEYOND;
        end else begin
            status = ST_INSERT;
        end
        n_result.status         = status;
        n_result.insert_offset  = (status == ST_INSERT) ? n_cand : '0;
        n_result.segment_length = (status == ST_INSERT) ? r_blob_length + LEN_FIELD_OH
                                                        : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_phase         <= PH_SOI0;
            r_length_high   <= '0;
            r_cand          <= CAND_RESET;
            r_settled       <= 1'b0;
            r_fault         <= FLT_NONE;
        end else if (in_xfer) begin
            if (i_in.last_byte) begin
                r_byte_position <= '0;
                r_phase         <= PH_SOI0;
                r_length_high   <= '0;
                r_cand          <= CAND_RESET;
                r_settled       <= 1'b0;
                r_fault         <= FLT_NONE;
            end else begin
                r_byte_position <= n_byte_position;
                r_phase         <= n_phase;
                r_length_high   <= n_length_high;
                r_cand          <= n_cand;
                r_settled       <= n_settled;
                r_fault         <= n_fault;
            end
        end
    end

    assign push = in_xfer && i_in.last_byte;
    assign pop  = r_out_valid && o_out.ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (pop) begin
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                n_skid_valid = 1'b1;
            end else begin
                n_out_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_ready      <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            r_ready      <= !n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.insert_offset  = r_out.insert_offset;
    assign o_out.segment_length = r_out.segment_length;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid entry held without a result at the output.");

    a_settled_in_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settled |-> (r_phase == PH_SEEK))
        else $error("Offset settled outside the seek phase.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_byte_position == '0 && r_phase == PH_SOI0 && r_out_valid))
        else $error("Last byte did not restart the parser and post a result.");

    a_zero_unless_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_INSERT) |->
            (r_out.insert_offset == '0 && r_out.segment_length == '0))
        else $error("Nonzero offset or length with a non-insert status.");
`endif

endmodule

>>> verif/jaip_insert_point_checker.sv
`timescale 1ns / 1ps

module jaip_insert_point_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    jaip_in_if                            in_ch,
    jaip_out_if                           out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jaip_pkg::ADDR_W-1:0]   paddr,
    input  logic [jaip_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    output int                            o_mismatch_count,
    output int                            o_results_owed,
    output int                            o_results_checked
);
    import jaip_pkg::*;

    localparam logic [ADDR_W-1:0] BLOB_ADDR = ADDR_W'(4 * REG_BLOB_LENGTH);

    logic [LEN_W-1:0]  blob_len;
    logic [POS_W-1:0]  byte_pos;
    logic [POS_W-1:0]  cand_offset;
    logic [BYTE_W-1:0] len_hi;
    logic              offset_done;
    t_phase            phase;
    t_fault            fault;
    t_result           insert_points_q[$];
    int                mismatches;
    int                checked;

    function automatic void clear_parser();
        byte_pos    = '0;
        phase       = PH_SOI0;
        len_hi      = '0;
        cand_offset = CAND_RESET;
        offset_done = 1'b0;
        fault       = FLT_NONE;
    endfunction

    function automatic void settle_offset();
        offset_done = 1'b1;
        phase       = PH_SEEK;
    endfunction

    function automatic void scan_marker_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        logic [POS_W-1:0] pos;
        logic [POS_W:0]   next_off;
        logic [POS_W:0]   file_size;
        t_result          r;
        pos = byte_pos;
        case (phase)
            PH_SOI0: begin
                if (b == MARK_FF) begin
                    phase = PH_SOI1;
                end else begin
                    fault = FLT_SOI;
                    settle_offset();
                end
            end
            PH_SOI1: begin
                if (b == MARK_SOI) begin
                    phase = PH_APP0FF;
                end else begin
                    fault = FLT_SOI;
                    settle_offset();
                end
            end
            PH_APP0FF: begin
                if (b == MARK_FF) phase = PH_APP0ID;
                else settle_offset();
            end
            PH_APP0ID: begin
                if (b == MARK_APP0) phase = PH_LENHI;
                else settle_offset();
            end
            PH_LENHI: begin
                len_hi = b;
                phase  = PH_LENLO;
            end
            PH_LENLO: begin
                next_off = {1'b0, cand_offset} + (POS_W+1)'(2) + {17'd0, len_hi, b};
                if (next_off[POS_W]) begin
                    cand_offset = '1;
                    fault       = FLT_OVF;
                    settle_offset();
                end else begin
                    cand_offset = next_off[POS_W-1:0];
                    phase       = PH_SEEK;
                    if (next_off <= {1'b0, pos}) offset_done = 1'b1;
                end
            end
            PH_SEEK: begin
                if (!offset_done && pos == cand_offset) begin
                    if (b == MARK_FF) phase = PH_APP2ID;
                    else settle_offset();
                end
            end
            default: begin
                if (b == MARK_APP2) phase = PH_LENHI;
                else settle_offset();
            end
        endcase
        if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
        if (is_last) begin
            file_size = {1'b0, pos} + 1'b1;
            if (file_size < 4 || blob_len == '0 || blob_len > MAX_BLOB) r.status = ST_SHORT;
            else if (fault == FLT_SOI) r.status = ST_BAD_SOI;
            else if (fault == FLT_OVF || {1'b0, cand_offset} > file_size) r.status = ST_BEYOND;
            else r.status = ST_INSERT;
            r.insert_offset  = (r.status == ST_INSERT) ? cand_offset : '0;
            r.segment_length = (r.status == ST_INSERT) ? blob_len + LEN_FIELD_OH : '0;
            insert_points_q.insert(insert_points_q.size(), r);
            clear_parser();
        end
    endfunction

    function automatic void report_mismatch(input string what, input t_result want);
        if (mismatches < 10) begin
            $display("%s: expected status=%0d offset=%0d length=%0d,",
                     what, want.status, want.insert_offset, want.segment_length);
            $display("    got status=%0d offset=%0d length=%0d",
                     out_ch.status, out_ch.insert_offset, out_ch.segment_length);
        end
        mismatches++;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            blob_len = '0;
            clear_parser();
            insert_points_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == BLOB_ADDR) begin
                blob_len = pwdata[LEN_W-1:0];
            end
            if (in_ch.valid && in_ch.ready) begin
                scan_marker_byte(in_ch.image_byte, in_ch.last_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (insert_points_q.size() == 0) begin
                    want = '0;
                    report_mismatch("Result transfer with nothing expected", want);
                end else begin
                    want = insert_points_q.pop_front();
                    checked++;
                    if (out_ch.status !== want.status ||
                        out_ch.insert_offset !== want.insert_offset ||
                        out_ch.segment_length !== want.segment_length) begin
                        report_mismatch("Result mismatch", want);
                    end
                end
            end
        end
        o_mismatch_count  <= mismatches;
        o_results_owed    <= insert_points_q.size();
        o_results_checked <= checked;
    end

endmodule

>>> verif/tb_jpeg_app1_insert_point_finder_core.sv
`timescale 1ns / 1ps

module tb_jpeg_app1_insert_point_finder_core;
    import jaip_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam logic [ADDR_W-1:0] BLOB_ADDR = ADDR_W'(4 * REG_BLOB_LENGTH);

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    jaip_in_if  in_ch();
    jaip_out_if out_ch();

    int mismatch_count;
    int results_owed;
    int results_checked;

    int tx_idle_pct;
    int rx_idle_pct;
    int stall_left;
    logic long_stall_req;
    logic long_stall_done;
    int cycle_count = 0;

    logic [BYTE_W-1:0] file_q[$];
    int files_sent;
    int bytes_sent;
    int settings_used;

    jpeg_app1_insert_point_finder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    jaip_insert_point_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .in_ch             (in_ch),
        .out_ch            (out_ch),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .o_mismatch_count  (mismatch_count),
        .o_results_owed    (results_owed),
        .o_results_checked (results_checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The output side stalls at random, and once holds off long enough to back up the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready    <= 1'b0;
            stall_left      <= 0;
            long_stall_done <= 1'b0;
        end else if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            out_ch.ready    <= 1'b0;
            stall_left      <= 400;
            long_stall_done <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.image_byte <= b;
        in_ch.last_byte  <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) begin
            send_byte(file_q[i], i == file_q.size() - 1);
        end
        files_sent++;
        bytes_sent += file_q.size();
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_blob(input logic [LEN_W-1:0] blob);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BLOB_ADDR;
        pwdata  <= {16'($urandom), blob};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int r = $urandom_range(99);
        if (r < 80) return LEN_W'($urandom_range(12, 2));
        if (r < 90) return LEN_W'($urandom_range(1));
        return LEN_W'($urandom);
    endfunction

    function automatic void put_byte(input logic [BYTE_W-1:0] b);
        file_q.insert(file_q.size(), b);
    endfunction

    function automatic void add_segment(input logic [BYTE_W-1:0] marker,
                                        input logic [LEN_W-1:0] len);
        int payload;
        put_byte(MARK_FF);
        put_byte(marker);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        payload = (len < 2) ? 0 : (len > 14) ? $urandom_range(6) : len - 2;
        repeat (payload) put_byte(BYTE_W'($urandom));
    endfunction

    // Mostly well-formed headers with random content; some corrupted, truncated or pure noise.
    function automatic void build_random_file();
        int kind;
        int n;
        int cut;
        file_q.delete();
        kind = $urandom_range(99);
        if (kind >= 85) begin
            n = $urandom_range(12, 1);
            if ($urandom_range(1)) begin
                put_byte(MARK_FF);
                put_byte(MARK_SOI);
            end
            repeat (n) put_byte(BYTE_W'($urandom));
            return;
        end
        put_byte(MARK_FF);
        put_byte(MARK_SOI);
        if ($urandom_range(99) < 85) begin
            add_segment(MARK_APP0, pick_length());
            repeat ($urandom_range(2)) add_segment(MARK_APP2, pick_length());
        end else if ($urandom_range(1)) begin
            add_segment(MARK_APP2, pick_length());
        end
        put_byte(MARK_FF);
        put_byte(BYTE_W'($urandom_range(8'hFE, 8'hC0)));
        repeat ($urandom_range(4)) put_byte(BYTE_W'($urandom));
        if (kind >= 70) file_q[$urandom_range(file_q.size() - 1)] = BYTE_W'($urandom);
        if ($urandom_range(99) < 25) begin
            cut = $urandom_range(file_q.size(), 1);
            while (file_q.size() > cut) void'(file_q.pop_back());
        end
    endfunction

    initial begin
        logic [LEN_W-1:0] blob;
        int byte_goal;
        int file_goal;
        int phase_bytes;
        int phase_files;

        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.image_byte = '0;
        in_ch.last_byte  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        long_stall_req   = 1'b0;
        tx_idle_pct      = 10;
        rx_idle_pct      = 72;
        files_sent       = 0;
        bytes_sent       = 0;
        settings_used    = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the blob length still at its reset value of zero there is nothing to insert.
        file_q = '{MARK_FF, MARK_SOI, MARK_FF, 8'hDB};
        send_file();
        drain_results();
        write_blob(16'd16);

        // A single-byte file, a two-byte file, and a broken SOI marker.
        file_q = '{8'h00};
        send_file();
        file_q = '{MARK_FF, MARK_SOI};
        send_file();
        file_q = '{MARK_FF, 8'hD9, 8'h00, 8'hFF};
        send_file();
        // The APP0 length bytes are cut off, so the offset stays at the marker.
        file_q = '{MARK_FF, MARK_SOI, MARK_FF, MARK_APP0};
        send_file();
        // An APP0 length of zero points back before the byte just read.
        file_q = '{MARK_FF, MARK_SOI, MARK_FF, MARK_APP0, 8'h00, 8'h00, MARK_FF};
        send_file();
        // The offset lands exactly on the end of the file.
        file_q = '{MARK_FF, MARK_SOI, MARK_FF, MARK_APP0, 8'h00, 8'h02};
        send_file();
        drain_results();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: blob = 16'd1;
                1: blob = MAX_BLOB;
                2: blob = 16'hFFFF;
                3: blob = LEN_W'($urandom_range(65532, 2));
                4: blob = 16'd0;
                5: blob = MAX_BLOB + 1'b1;
                default: blob = LEN_W'($urandom_range(65532, 2));
            endcase
            if (ph < 2) begin
                tx_idle_pct = 10;
                rx_idle_pct = 72;
            end else if (ph < 4) begin
                tx_idle_pct = 72;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_blob(blob);
            if (ph == 6) long_stall_req <= 1'b1;
            if (blob == '0 || blob > MAX_BLOB) begin
                byte_goal = 20;
                file_goal = 2;
            end else begin
                byte_goal = 60;
                file_goal = 5;
            end
            phase_bytes = 0;
            phase_files = 0;
            while (phase_bytes < byte_goal || phase_files < file_goal) begin
                build_random_file();
                send_file();
                phase_bytes += file_q.size();
                phase_files++;
            end
            drain_results();
        end

        $display("Run covered %0d JPEG streams, %0d bytes, under %0d blob_length settings,",
                 files_sent, bytes_sent, settings_used);
        $display("with source and sink stalls and one long output hold-off; %0d results checked.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
